// ===== rtl/matrix_chain_order_macros.svh =====
// assertion macros for the matrix chain order checker
// expects clk and rst_n in the scope where a macro is used
`ifndef MATRIX_CHAIN_ORDER_MACROS_SVH
`define MATRIX_CHAIN_ORDER_MACROS_SVH

// same-cycle implication
`define MCO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MCO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mco_pkg.sv =====
// shared types, widths and codes for the matrix chain order block
// no dependencies
package mco_pkg;

  localparam int MAX_MATRICES_DEF = 16;
  localparam int DIM_WIDTH_DEF    = 16;

  localparam int DIM_IN_W = 16;
  localparam int COST_W   = 63;
  localparam int SPLIT_W  = 5;
  localparam int STATUS_W = 2;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LONG  = 2'd2;

  typedef struct packed {
    logic [DIM_IN_W-1:0] dimension;
    logic                last;
  } in_word_t;

  typedef struct packed {
    logic [COST_W-1:0]   min_cost;
    logic [SPLIT_W-1:0]  top_split;
    logic [STATUS_W-1:0] status;
  } out_word_t;

  typedef struct packed {
    logic load_di;
    logic load_ac;
    logic load_step;
    logic load_sum;
    logic zero_a;
    logic zero_b;
  } arith_ctl_t;

endpackage

// ===== rtl/matrix_chain_order.sv =====
// matrix chain order: sequencer, dimension store and result register
// depends on mco_pkg, mco_arith and mco_cost_mem
//
// usage:
//   in channel: one dimension word per accept, last set on the final one.
//   non-last words are accepted one per cycle and stored while the store has room.
//   out channel: one result word per last word (cost, top split, status).
//   a chain of n matrices runs the interval dp after its last word; each
//   split step goes through the shared multiplier, the cost memory read
//   ports and the saturating adds.
//   bad chains (too short, too long) answer from the push state without running the dp.
//   in_stall is high from the last word until the result enters the
//   output register; a stalled result holds there and blocks the next one.
//   reset clears the fill count, the overflow flag and the output valid.
module matrix_chain_order import mco_pkg::*; #(
  parameter int MAX_MATRICES = MAX_MATRICES_DEF,
  parameter int DIM_WIDTH    = DIM_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int STORE_DEPTH = MAX_MATRICES + 1;
  localparam int SEQ_W       = $clog2(MAX_MATRICES + 2);
  localparam int DADDR_W     = $clog2(MAX_MATRICES + 1);
  localparam int IDX_W       = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
  localparam int EXT_W       = DIM_IN_W + DIM_WIDTH;
  localparam int SPL_EXT_W   = SEQ_W + SPLIT_W;

  localparam logic [SEQ_W-1:0] STORE_CNT = SEQ_W'(STORE_DEPTH);
  localparam logic [SEQ_W-1:0] ONE       = SEQ_W'(1);
  localparam logic [SEQ_W-1:0] TWO       = SEQ_W'(2);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_LOADI = 10'b0000000010,
    ST_LOADJ = 10'b0000000100,
    ST_AC    = 10'b0000001000,
    ST_RD    = 10'b0000010000,
    ST_MUL   = 10'b0000100000,
    ST_ADD   = 10'b0001000000,
    ST_CMP   = 10'b0010000000,
    ST_WR    = 10'b0100000000,
    ST_PUSH  = 10'b1000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [SEQ_W-1:0]    count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  logic [SEQ_W-1:0]    n_r, n_nxt;
  logic [SEQ_W-1:0]    len_r, len_nxt;
  logic [SEQ_W-1:0]    i_r, i_nxt;
  logic [SEQ_W-1:0]    k_r, k_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [COST_W-1:0]   best_r, best_nxt;
  logic [SEQ_W-1:0]    bestk_r, bestk_nxt;
  logic                diag_a_r, diag_a_nxt;
  logic                diag_b_r, diag_b_nxt;
  logic [COST_W-1:0]   res_cost_r, res_cost_nxt;
  logic [SEQ_W-1:0]    res_split_r, res_split_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  out_word_t           out_data_r, out_data_nxt;

  logic [DIM_WIDTH-1:0] dim_mem [STORE_DEPTH];
  logic [DIM_WIDTH-1:0] dim_rdata_r;

  logic                 in_accept;
  logic [EXT_W-1:0]     dim_ext;
  logic [DIM_WIDTH-1:0] dim_in;
  logic                 dim_wr;
  logic [SEQ_W-1:0]     dim_rsel;
  logic [SEQ_W-1:0]     j, j1, jm1, k1;
  logic [SEQ_W-1:0]     cnt_after;
  logic                 ovf_after;
  logic                 push_fire;
  logic [SPL_EXT_W-1:0] split_ext;

  arith_ctl_t           ctl;
  logic [COST_W-1:0]    cand;
  logic [COST_W-1:0]    cost_a, cost_b;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign dim_ext = EXT_W'(in_data.dimension);
  assign dim_in  = dim_ext[DIM_WIDTH-1:0];
  assign dim_wr  = in_accept && (count_r < STORE_CNT);

  assign j   = i_r + len_r - ONE;
  assign j1  = j + ONE;
  assign jm1 = j - ONE;
  assign k1  = k_r + ONE;

  assign push_fire = (state_r == ST_PUSH) && (!out_valid_r || !out_stall);
  assign split_ext = SPL_EXT_W'(res_split_r);

  always_comb begin
    case (state_r)
      ST_LOADI: dim_rsel = i_r;
      ST_LOADJ: dim_rsel = j1;
      ST_RD:    dim_rsel = k1;
      default:  dim_rsel = i_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dim_wr) begin
      dim_mem[count_r[DADDR_W-1:0]] <= dim_in;
    end
    dim_rdata_r <= dim_mem[dim_rsel[DADDR_W-1:0]];
  end

  assign ctl.load_di   = (state_r == ST_LOADJ);
  assign ctl.load_ac   = (state_r == ST_AC);
  assign ctl.load_step = (state_r == ST_MUL);
  assign ctl.load_sum  = (state_r == ST_ADD);
  assign ctl.zero_a    = diag_a_r;
  assign ctl.zero_b    = diag_b_r;

  mco_arith #(
    .DIM_WIDTH (DIM_WIDTH)
  ) u_arith (
    .clk    (clk),
    .ctl    (ctl),
    .dim_rd (dim_rdata_r),
    .cost_a (cost_a),
    .cost_b (cost_b),
    .cand_r (cand)
  );

  mco_cost_mem #(
    .IDX_W (IDX_W)
  ) u_cost_mem (
    .clk       (clk),
    .we        (state_r == ST_WR),
    .waddr     ({i_r[IDX_W-1:0], j[IDX_W-1:0]}),
    .wdata     (best_r),
    .raddr_a   ({i_r[IDX_W-1:0], k_r[IDX_W-1:0]}),
    .raddr_b   ({k1[IDX_W-1:0], j[IDX_W-1:0]}),
    .rdata_a_r (cost_a),
    .rdata_b_r (cost_b)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    n_nxt          = n_r;
    len_nxt        = len_r;
    i_nxt          = i_r;
    k_nxt          = k_r;
    best_nxt       = best_r;
    bestk_nxt      = bestk_r;
    diag_a_nxt     = diag_a_r;
    diag_b_nxt     = diag_b_r;
    res_cost_nxt   = res_cost_r;
    res_split_nxt  = res_split_r;
    res_status_nxt = res_status_r;
    cnt_after      = count_r;
    ovf_after      = ovf_r;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (count_r < STORE_CNT) begin
            cnt_after = count_r + ONE;
          end else begin
            ovf_after = 1'b1;
          end
          if (!in_data.last) begin
            count_nxt = cnt_after;
            ovf_nxt   = ovf_after;
          end else begin
            count_nxt      = '0;
            ovf_nxt        = 1'b0;
            res_cost_nxt   = '0;
            res_split_nxt  = '0;
            res_status_nxt = STATUS_OK;
            state_nxt      = ST_PUSH;
            if (ovf_after) begin
              res_status_nxt = STATUS_LONG;
            end else if (cnt_after < TWO) begin
              res_status_nxt = STATUS_SHORT;
            end else if (cnt_after > TWO) begin
              n_nxt     = cnt_after - ONE;
              len_nxt   = TWO;
              i_nxt     = '0;
              state_nxt = ST_LOADI;
            end
          end
        end
      end
      ST_LOADI: state_nxt = ST_LOADJ;
      ST_LOADJ: state_nxt = ST_AC;
      ST_AC: begin
        k_nxt     = i_r;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        diag_a_nxt = (k_r == i_r);
        diag_b_nxt = (k1 == j);
        state_nxt  = ST_MUL;
      end
      ST_MUL: state_nxt = ST_ADD;
      ST_ADD: state_nxt = ST_CMP;
      ST_CMP: begin
        // strict compare keeps the first split on ties
        if ((k_r == i_r) || (cand < best_r)) begin
          best_nxt  = cand;
          bestk_nxt = k_r;
        end
        if (k_r == jm1) begin
          state_nxt = ST_WR;
        end else begin
          k_nxt     = k1;
          state_nxt = ST_RD;
        end
      end
      ST_WR: begin
        if (len_r == n_r) begin
          res_cost_nxt   = best_r;
          res_split_nxt  = bestk_r + ONE;
          res_status_nxt = STATUS_OK;
          state_nxt      = ST_PUSH;
        end else if ((i_r + len_r) == n_r) begin
          len_nxt   = len_r + ONE;
          i_nxt     = '0;
          state_nxt = ST_LOADI;
        end else begin
          i_nxt     = i_r + ONE;
          state_nxt = ST_LOADI;
        end
      end
      ST_PUSH: begin
        if (push_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (push_fire) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.min_cost  = res_cost_r;
      out_data_nxt.top_split = split_ext[SPLIT_W-1:0];
      out_data_nxt.status    = res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      n_r         <= '0;
      len_r       <= '0;
      i_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      n_r         <= n_nxt;
      len_r       <= len_nxt;
      i_r         <= i_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r       <= best_nxt;
    bestk_r      <= bestk_nxt;
    diag_a_r     <= diag_a_nxt;
    diag_b_r     <= diag_b_nxt;
    res_cost_r   <= res_cost_nxt;
    res_split_r  <= res_split_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

// ===== rtl/mco_cost_mem.sv =====
// cost table memory: one write port, two registered read ports
// depends on mco_pkg
module mco_cost_mem import mco_pkg::*; #(
  parameter int IDX_W = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [2*IDX_W-1:0]   waddr,
  input  logic [COST_W-1:0]    wdata,
  input  logic [2*IDX_W-1:0]   raddr_a,
  input  logic [2*IDX_W-1:0]   raddr_b,
  output logic [COST_W-1:0]    rdata_a_r,
  output logic [COST_W-1:0]    rdata_b_r
);

  localparam int DEPTH = 1 << (2*IDX_W);

  logic [COST_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

endmodule

// ===== rtl/mco_arith.sv =====
// shared arithmetic unit: one multiplier and saturating cost adders
// depends on mco_pkg
module mco_arith import mco_pkg::*; #(
  parameter int DIM_WIDTH = DIM_WIDTH_DEF
) (
  input  logic                 clk,
  input  arith_ctl_t           ctl,
  input  logic [DIM_WIDTH-1:0] dim_rd,
  input  logic [COST_W-1:0]    cost_a,
  input  logic [COST_W-1:0]    cost_b,
  output logic [COST_W-1:0]    cand_r
);

  localparam int AC_W   = 2*DIM_WIDTH;
  localparam int PROD_W = 3*DIM_WIDTH;

  logic [DIM_WIDTH-1:0] di_r;
  logic [AC_W-1:0]      ac_r;
  logic [PROD_W-1:0]    prod_r;
  logic [COST_W-1:0]    pair_r;

  logic [AC_W-1:0]      mul_x;
  logic [PROD_W-1:0]    mul_p;
  logic [COST_W-1:0]    term_a;
  logic [COST_W-1:0]    term_b;

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, COST_MAX}) ? COST_MAX : s[COST_W-1:0];
  endfunction

  // outer dims product first, then one inner dim per split step
  assign mul_x  = ctl.load_ac ? AC_W'(di_r) : ac_r;
  assign mul_p  = PROD_W'(mul_x) * PROD_W'(dim_rd);
  assign term_a = ctl.zero_a ? '0 : cost_a;
  assign term_b = ctl.zero_b ? '0 : cost_b;

  always_ff @(posedge clk) begin
    if (ctl.load_di) begin
      di_r <= dim_rd;
    end
    if (ctl.load_ac) begin
      ac_r <= mul_p[AC_W-1:0];
    end
    if (ctl.load_step) begin
      prod_r <= mul_p;
      pair_r <= sat_add(term_a, term_b);
    end
    if (ctl.load_sum) begin
      cand_r <= sat_add(pair_r, COST_W'(prod_r));
    end
  end

endmodule

// ===== rtl/mco_checker.sv =====
// port-level checker for the matrix chain order block, bound to the top level
// depends on mco_pkg and matrix_chain_order_macros.svh
`include "matrix_chain_order_macros.svh"

module mco_checker import mco_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  // a stalled result word holds
  `MCO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result word changed while stalled")

  // error results carry no cost and no split
  `MCO_ASSERT_NOW(a_err_empty, out_valid && (out_data.status != STATUS_OK), (out_data.min_cost == '0) && (out_data.top_split == '0), "error result with nonzero cost or split")

  // a result never appears right after an accepted word
  `MCO_ASSERT_NEXT(a_no_early_result, in_valid && !in_stall, !$rose(out_valid), "result word too early after an input word")

  // the block goes busy after a last word
  `MCO_ASSERT_NEXT(a_busy_after_last, in_valid && !in_stall && in_data.last, in_stall, "input not stalled after last word")

endmodule

bind matrix_chain_order mco_checker u_mco_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== dv/matrix_chain_order_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for matrix_chain_order: a directed table, then random chains
// predicts cost, top split and status from the table or with its own interval dp; needs mco_pkg and the rtl
module matrix_chain_order_tb;
  import mco_pkg::*;

  localparam int MATRICES = 16;
  localparam int STORE_DEPTH = MATRICES + 1;
  localparam logic [63:0] COST_CEILING = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int RANDOM_WORDS = 450;
  localparam int QUIET_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 3300;
  localparam int ROWS = 25;

  typedef struct packed {
    logic [DIM_IN_W-1:0] dimension;
    logic last;
    int reps;
    logic typed;
    out_word_t answer;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;

  logic [DIM_IN_W-1:0] dim_store [0:STORE_DEPTH-1];
  int unsigned dim_count = 0;
  logic overflow_seen = 1'b0;
  out_word_t chain_answers [$];
  int unsigned mismatch_count = 0;
  int unsigned kept_words = 0;
  int unsigned quiet_cycles = 0;
  int unsigned in_gap_odds = 0;
  int unsigned out_gap_odds = 0;

  wire in_fire = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  stim_row_t directed [0:ROWS-1] = '{
    '{16'd1,     1'b1, 1,  1'b1, '{63'd0, 5'd0, STATUS_SHORT}},
    '{16'hFFFF,  1'b0, 1,  1'b0, '0},
    '{16'hFFFF,  1'b1, 1,  1'b1, '{63'd0, 5'd0, STATUS_OK}},
    '{16'hFFFF,  1'b0, 2,  1'b0, '0},
    '{16'hFFFF,  1'b1, 1,  1'b1, '{63'h0000_FFFD_0002_FFFF, 5'd1, STATUS_OK}},
    '{16'd1,     1'b0, 2,  1'b0, '0},
    '{16'd1,     1'b1, 1,  1'b1, '{63'd1, 5'd1, STATUS_OK}},
    '{16'd0,     1'b0, 1,  1'b0, '0},
    '{16'd5,     1'b0, 1,  1'b0, '0},
    '{16'd7,     1'b1, 1,  1'b0, '0},
    '{16'd10,    1'b0, 3,  1'b0, '0},
    '{16'd10,    1'b1, 1,  1'b0, '0},
    '{16'd30,    1'b0, 1,  1'b0, '0},
    '{16'd35,    1'b0, 1,  1'b0, '0},
    '{16'd15,    1'b0, 1,  1'b0, '0},
    '{16'd5,     1'b0, 1,  1'b0, '0},
    '{16'd10,    1'b0, 1,  1'b0, '0},
    '{16'd20,    1'b0, 1,  1'b0, '0},
    '{16'd25,    1'b1, 1,  1'b0, '0},
    '{16'hFFFF,  1'b0, 16, 1'b0, '0},
    '{16'hFFFF,  1'b1, 1,  1'b0, '0},
    '{16'h1234,  1'b0, 17, 1'b0, '0},
    '{16'd1,     1'b1, 1,  1'b1, '{63'd0, 5'd0, STATUS_LONG}},
    '{16'd3,     1'b0, 24, 1'b0, '0},
    '{16'd9,     1'b1, 1,  1'b1, '{63'd0, 5'd0, STATUS_LONG}}
  };

  matrix_chain_order dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, COST_CEILING}) ? COST_CEILING : s[63:0];
  endfunction

  function automatic out_word_t solve_chain();
    logic [63:0] cost [0:MATRICES-1][0:MATRICES-1];
    logic [SPLIT_W-1:0] cut_at [0:MATRICES-1][0:MATRICES-1];
    logic [63:0] trial;
    logic [63:0] best;
    int n, len, i, j, k, best_k;
    out_word_t r;
    r = '0;
    r.status = STATUS_OK;
    if (overflow_seen) begin
      r.status = STATUS_LONG;
    end else if (dim_count < 2) begin
      r.status = STATUS_SHORT;
    end else begin
      n = dim_count - 1;
      for (i = 0; i < n; i++) begin
        cost[i][i] = '0;
        cut_at[i][i] = '0;
      end
      for (len = 2; len <= n; len++) begin
        for (i = 0; i + len <= n; i++) begin
          j = i + len - 1;
          best = '0;
          best_k = i;
          for (k = i; k < j; k++) begin
            trial = sat_sum(sat_sum(cost[i][k], cost[k+1][j]),
                            64'(dim_store[i]) * 64'(dim_store[k+1]) * 64'(dim_store[j+1]));
            // ties keep the first split
            if (k == i || trial < best) begin
              best = trial;
              best_k = k;
            end
          end
          cost[i][j] = best;
          cut_at[i][j] = SPLIT_W'(best_k + 1);
        end
      end
      r.min_cost = cost[0][n-1][COST_W-1:0];
      r.top_split = (n == 1) ? '0 : cut_at[0][n-1];
    end
    return r;
  endfunction

  function automatic void log_word(in_word_t w, logic typed, out_word_t answer);
    if (dim_count < STORE_DEPTH) begin
      dim_store[dim_count] = w.dimension;
      dim_count++;
      kept_words++;
    end else begin
      overflow_seen = 1'b1;
    end
    if (w.last) begin
      chain_answers.push_back(typed ? answer : solve_chain());
      dim_count = 0;
      overflow_seen = 1'b0;
    end
  endfunction

  function automatic logic [DIM_IN_W-1:0] pick_dimension();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll < 3) return '1;
    if (roll < 10) return DIM_IN_W'($urandom_range(1, 12));
    return DIM_IN_W'($urandom_range(1, 65535));
  endfunction

  function automatic int unsigned pick_odds();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 12;
    endcase
  endfunction

  task automatic flag_mismatch(string what);
    mismatch_count++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic check_answer(out_word_t got);
    out_word_t want;
    if (chain_answers.size() == 0) begin
      flag_mismatch($sformatf("result word %h with no chain pending", got));
      return;
    end
    want = chain_answers.pop_front();
    if (got.min_cost !== want.min_cost)
      flag_mismatch($sformatf("min_cost %0d, predicted %0d", got.min_cost, want.min_cost));
    if (got.top_split !== want.top_split)
      flag_mismatch($sformatf("top_split %0d, predicted %0d", got.top_split, want.top_split));
    if (got.status !== want.status)
      flag_mismatch($sformatf("status %0d, predicted %0d", got.status, want.status));
  endtask

  task automatic send_word(in_word_t w, logic typed, out_word_t answer);
    @(negedge clk);
    if (in_gap_odds != 0 && $urandom_range(1, in_gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    log_word(w, typed, answer);
  endtask

  task automatic send_chain(int len);
    int i;
    in_word_t w;
    for (i = 0; i < len; i++) begin
      w.dimension = pick_dimension();
      w.last = (i == len - 1);
      send_word(w, 1'b0, '0);
    end
  endtask

  // receiver stall bursts
  initial begin
    forever begin
      @(negedge clk);
      if (out_gap_odds != 0 && $urandom_range(1, out_gap_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_fire) check_answer(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || in_fire || out_fire) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned r, n, sel, len;
    in_word_t word;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    in_gap_odds = 4;
    out_gap_odds = 5;
    for (r = 0; r < ROWS; r++) begin
      for (n = 0; n < directed[r].reps; n++) begin
        word.dimension = directed[r].dimension;
        word.last = directed[r].last;
        send_word(word, directed[r].typed, directed[r].answer);
      end
    end

    kept_words = 0;
    while (kept_words < RANDOM_WORDS) begin
      if (kept_words < RANDOM_WORDS * 4 / 5) begin
        in_gap_odds = pick_odds();
        out_gap_odds = pick_odds();
      end else begin
        in_gap_odds = 0;
        out_gap_odds = 0;
      end
      sel = $urandom_range(0, 99);
      if (sel < 8) len = 1;
      else if (sel < 16) len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 5);
      else if (sel < 22) len = STORE_DEPTH;
      else if (sel < 27) len = 2;
      else len = $urandom_range(3, 9);
      send_chain(len);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (chain_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== matrix_chain_order.f =====
+incdir+rtl
rtl/mco_pkg.sv
rtl/mco_cost_mem.sv
rtl/mco_arith.sv
rtl/matrix_chain_order.sv
rtl/mco_checker.sv
dv/matrix_chain_order_tb.sv
